// ===== rtl/core/mfd_pkg.sv =====
// Shared types and constants for the meter frame deframer.
// No dependencies; used by every module under rtl/core.
`timescale 1ns / 1ps
`default_nettype none
package mfd_pkg;

  localparam int unsigned RxDepthDef      = 8192;
  localparam int unsigned PayloadDepthDef = 4096;
  localparam int unsigned MaxLenReset     = 4096;
  localparam int unsigned LenW            = 13;

  localparam logic [7:0] MarkStart = 8'h68;
  localparam logic [7:0] MarkEnd   = 8'h16;
  localparam int unsigned HdrBytes = 11;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_FRAME   = 2'd1,
    ST_PAYLOAD = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    ACT_PUSH = 1'b0,
    ACT_READ = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HUNT,
    S_RD,
    S_WT,
    S_CHECK,
    S_PRD,
    S_PWT,
    S_EMIT
  } eng_state_e;

  typedef enum logic [2:0] {
    PH_HDR,
    PH_SUM,
    PH_CHK,
    PH_END,
    PH_COPY
  } phase_e;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [15:0]     rtua;
    logic [15:0]     terminal_id;
    logic [5:0]      master_station;
    logic [6:0]      frame_seq;
    logic [2:0]      intra_seq;
    logic [5:0]      func_code;
    logic            abnormal;
    logic            direction;
    logic [LenW-1:0] payload_len;
    logic [7:0]      payload_byte;
    logic            last;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/core/mfd_in_queue.sv =====
// Front end: two-entry queue of input items ahead of the frame engine.
// Depends on mfd_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none
module mfd_in_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  mfd_pkg::item_t     item_i,
  output logic               full_o,
  output logic               valid_o,
  output mfd_pkg::item_t     item_o,
  input  wire logic          pop_i
);

  mfd_pkg::item_t slot_q [2];
  logic           wr_q, wr_d, rd_q, rd_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mfd_engine.sv =====
// Back end: receive buffer, frame hunt, checksum, payload store and readout.
// Depends on mfd_pkg for types, marks and reset values.
`timescale 1ns / 1ps
`default_nettype none
module mfd_engine #(
  parameter int unsigned RX_DEPTH      = mfd_pkg::RxDepthDef,
  parameter int unsigned PAYLOAD_DEPTH = mfd_pkg::PayloadDepthDef
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [mfd_pkg::LenW-1:0] cfg_wdata_i,
  input  wire logic                     item_valid_i,
  input  mfd_pkg::item_t                item_i,
  output logic                          item_pop_o,
  output logic                          res_valid_o,
  output mfd_pkg::res_t                 res_o,
  input  wire logic                     res_ready_i
);

  localparam int unsigned AW = $clog2(RX_DEPTH);
  localparam int unsigned FW = $clog2(RX_DEPTH + 1);
  localparam int unsigned PW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam int unsigned CW = $clog2(PAYLOAD_DEPTH + 1);
  localparam int unsigned LW = 18;

  logic [7:0] rx_mem [RX_DEPTH];
  logic [7:0] pl_mem [PAYLOAD_DEPTH];

  mfd_pkg::eng_state_e state_q, state_d;
  mfd_pkg::phase_e     phase_q, phase_d;
  logic [AW-1:0]  head_q, head_d;
  logic [FW-1:0]  fill_q, fill_d;
  logic [FW-1:0]  k_q, k_d;
  logic [7:0]     sum_q, sum_d;
  logic [7:0]     hdr_q [mfd_pkg::HdrBytes];
  logic [7:0]     hdr_d [mfd_pkg::HdrBytes];
  logic [CW-1:0]  count_q, count_d, pos_q, pos_d;
  logic [15:0]    rtua_q, rtua_d, tid_q, tid_d, ctl_q, ctl_d;
  logic [7:0]     code_q, code_d;
  logic [1:0]     status_q, status_d;
  logic [7:0]     pbyte_q, pbyte_d;
  logic           last_q, last_d;
  logic [mfd_pkg::LenW-1:0] max_len_q;

  logic           rx_we, rx_re, pl_we, pl_re;
  logic [AW-1:0]  rx_waddr, rx_raddr;
  logic [PW-1:0]  pl_waddr;
  logic [7:0]     rx_rdata_q, pl_rdata_q;
  logic           do_drop1, do_accept;
  logic [LW-1:0]  len, k_ext, frame_n;
  logic           show;

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base, input logic [AW:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + off;
    if (s >= (AW+1)'(RX_DEPTH)) begin
      s = s - (AW+1)'(RX_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign len     = LW'({hdr_q[10], hdr_q[9]});
  assign k_ext   = LW'(k_q);
  assign frame_n = len + LW'(mfd_pkg::HdrBytes + 2);

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    head_d   = head_q;
    fill_d   = fill_q;
    k_d      = k_q;
    sum_d    = sum_q;
    hdr_d    = hdr_q;
    count_d  = count_q;
    pos_d    = pos_q;
    rtua_d   = rtua_q;
    tid_d    = tid_q;
    ctl_d    = ctl_q;
    code_d   = code_q;
    status_d = status_q;
    pbyte_d  = pbyte_q;
    last_d   = last_q;
    rx_we    = 1'b0;
    rx_re    = 1'b0;
    pl_we    = 1'b0;
    pl_re    = 1'b0;
    rx_waddr = wrap(head_q, (AW+1)'(fill_q));
    rx_raddr = wrap(head_q, (AW+1)'(k_q));
    pl_waddr = PW'(k_ext - LW'(mfd_pkg::HdrBytes));
    item_pop_o  = 1'b0;
    res_valid_o = 1'b0;
    do_drop1    = 1'b0;
    do_accept   = 1'b0;

    unique case (state_q)
      mfd_pkg::S_IDLE: begin
        status_d = mfd_pkg::ST_NONE;
        pbyte_d  = 8'd0;
        last_d   = 1'b0;
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          if (item_i.action == mfd_pkg::ACT_PUSH) begin
            if (fill_q == FW'(RX_DEPTH)) begin
              status_d = mfd_pkg::ST_FULL;
              state_d  = mfd_pkg::S_EMIT;
            end else begin
              rx_we   = 1'b1;
              fill_d  = fill_q + 1'b1;
              state_d = mfd_pkg::S_HUNT;
            end
          end else if (pos_q < count_q) begin
            state_d = mfd_pkg::S_PRD;
          end else begin
            state_d = mfd_pkg::S_EMIT;
          end
        end
      end
      mfd_pkg::S_HUNT: begin
        if (fill_q < FW'(mfd_pkg::HdrBytes)) begin
          state_d = mfd_pkg::S_EMIT;
        end else begin
          k_d     = '0;
          sum_d   = 8'd0;
          phase_d = mfd_pkg::PH_HDR;
          state_d = mfd_pkg::S_RD;
        end
      end
      mfd_pkg::S_RD: begin
        rx_re   = 1'b1;
        state_d = mfd_pkg::S_WT;
      end
      mfd_pkg::S_WT: begin
        state_d = mfd_pkg::S_RD;
        unique case (phase_q)
          mfd_pkg::PH_HDR: begin
            hdr_d[k_q[3:0]] = rx_rdata_q;
            sum_d = sum_q + rx_rdata_q;
            if (k_ext == LW'(mfd_pkg::HdrBytes - 1)) begin
              state_d = mfd_pkg::S_CHECK;
            end else begin
              k_d = k_q + 1'b1;
            end
          end
          mfd_pkg::PH_SUM: begin
            sum_d = sum_q + rx_rdata_q;
            if (k_ext == len + LW'(mfd_pkg::HdrBytes - 1)) begin
              phase_d = mfd_pkg::PH_CHK;
            end
            k_d = k_q + 1'b1;
          end
          mfd_pkg::PH_CHK: begin
            if (rx_rdata_q != sum_q) begin
              do_drop1 = 1'b1;
            end else begin
              phase_d = mfd_pkg::PH_END;
              k_d     = k_q + 1'b1;
            end
          end
          mfd_pkg::PH_END: begin
            if (rx_rdata_q != mfd_pkg::MarkEnd) begin
              do_drop1 = 1'b1;
            end else if (len == '0) begin
              do_accept = 1'b1;
            end else begin
              phase_d = mfd_pkg::PH_COPY;
              k_d     = FW'(mfd_pkg::HdrBytes);
            end
          end
          mfd_pkg::PH_COPY: begin
            pl_we = 1'b1;
            if (k_ext == len + LW'(mfd_pkg::HdrBytes - 1)) begin
              do_accept = 1'b1;
            end else begin
              k_d = k_q + 1'b1;
            end
          end
          default: begin
            do_drop1 = 1'b1;
          end
        endcase
      end
      mfd_pkg::S_CHECK: begin
        priority if (hdr_q[0] != mfd_pkg::MarkStart || hdr_q[7] != mfd_pkg::MarkStart) begin
          do_drop1 = 1'b1;
        end else if (len > LW'(max_len_q) || len > LW'(PAYLOAD_DEPTH) ||
                     frame_n > LW'(RX_DEPTH)) begin
          do_drop1 = 1'b1;
        end else if (hdr_q[2] == 8'd1 && hdr_q[3] == 8'd0 && hdr_q[6] == mfd_pkg::MarkEnd) begin
          do_drop1 = 1'b1;
        end else if (LW'(fill_q) < frame_n) begin
          state_d = mfd_pkg::S_EMIT;
        end else begin
          k_d     = FW'(mfd_pkg::HdrBytes);
          phase_d = (len == '0) ? mfd_pkg::PH_CHK : mfd_pkg::PH_SUM;
          state_d = mfd_pkg::S_RD;
        end
      end
      mfd_pkg::S_PRD: begin
        pl_re   = 1'b1;
        state_d = mfd_pkg::S_PWT;
      end
      mfd_pkg::S_PWT: begin
        status_d = mfd_pkg::ST_PAYLOAD;
        pbyte_d  = pl_rdata_q;
        last_d   = ((CW+1)'(pos_q) + 1'b1) == (CW+1)'(count_q);
        pos_d    = pos_q + 1'b1;
        state_d  = mfd_pkg::S_EMIT;
      end
      mfd_pkg::S_EMIT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = mfd_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = mfd_pkg::S_IDLE;
      end
    endcase

    if (do_drop1) begin
      head_d  = wrap(head_q, (AW+1)'(1));
      fill_d  = fill_q - 1'b1;
      state_d = mfd_pkg::S_HUNT;
    end
    if (do_accept) begin
      rtua_d   = {hdr_q[2], hdr_q[1]};
      tid_d    = {hdr_q[4], hdr_q[3]};
      ctl_d    = {hdr_q[6], hdr_q[5]};
      code_d   = hdr_q[8];
      count_d  = len[CW-1:0];
      pos_d    = '0;
      head_d   = wrap(head_q, frame_n[AW:0]);
      fill_d   = fill_q - FW'(frame_n);
      status_d = mfd_pkg::ST_FRAME;
      state_d  = mfd_pkg::S_EMIT;
    end
  end

  assign show = (status_q == mfd_pkg::ST_FRAME) || (status_q == mfd_pkg::ST_PAYLOAD);

  always_comb begin
    res_o                = '0;
    res_o.status         = status_q;
    res_o.payload_byte   = pbyte_q;
    res_o.last           = last_q;
    if (show) begin
      res_o.rtua           = rtua_q;
      res_o.terminal_id    = tid_q;
      res_o.master_station = ctl_q[5:0];
      res_o.frame_seq      = ctl_q[12:6];
      res_o.intra_seq      = ctl_q[15:13];
      res_o.func_code      = code_q[5:0];
      res_o.abnormal       = code_q[6];
      res_o.direction      = code_q[7];
      res_o.payload_len    = mfd_pkg::LenW'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mfd_pkg::S_IDLE;
      phase_q   <= mfd_pkg::PH_HDR;
      head_q    <= '0;
      fill_q    <= '0;
      k_q       <= '0;
      count_q   <= '0;
      pos_q     <= '0;
      rtua_q    <= '0;
      tid_q     <= '0;
      ctl_q     <= '0;
      code_q    <= '0;
      status_q  <= mfd_pkg::ST_NONE;
      max_len_q <= mfd_pkg::LenW'(mfd_pkg::MaxLenReset);
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      head_q   <= head_d;
      fill_q   <= fill_d;
      k_q      <= k_d;
      count_q  <= count_d;
      pos_q    <= pos_d;
      rtua_q   <= rtua_d;
      tid_q    <= tid_d;
      ctl_q    <= ctl_d;
      code_q   <= code_d;
      status_q <= status_d;
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q   <= sum_d;
    hdr_q   <= hdr_d;
    pbyte_q <= pbyte_d;
    last_q  <= last_d;
  end

  always_ff @(posedge clk_i) begin
    if (rx_we) begin
      rx_mem[rx_waddr] <= item_i.rx_byte;
    end
    if (rx_re) begin
      rx_rdata_q <= rx_mem[rx_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pl_we) begin
      pl_mem[pl_waddr] <= rx_rdata_q;
    end
    if (pl_re) begin
      pl_rdata_q <= pl_mem[pos_q[PW-1:0]];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/meter_frame_deframer.sv =====
// Top level of the meter frame deframer: input queue, frame engine, result register.
// Depends on mfd_pkg, mfd_in_queue and mfd_engine.
//
// Usage: items enter through push_i/full_o. action_i low pushes rx_byte_i into
// the receive buffer and runs a frame hunt at the buffer head; action_i high
// reads the next payload byte of the last accepted frame. Each item yields
// exactly one result, taken through empty_o/pop_i; status_o tells what it is.
// A buffer-full drop, a read with nothing left, a payload read and a push with
// fewer than 11 bytes buffered need no frame scan. Once 11 bytes wait, every
// header scan reads the header bytes one at a time, and a push that completes
// a frame also sums its payload, checks checksum and end mark, then copies the
// payload to the payload store. Each byte dropped during a rescan adds another
// scan, plus a pass that sums the payload when the length looked plausible and
// the whole frame was buffered. The single read port of the receive buffer sets
// this pace; one item is worked on at a time.
// Two items can wait in the input queue while the engine works, and one result
// waits in the output register; when pop_i stays low the engine holds its
// result and the input queue fills, then full_o rises.
// Reset empties the buffer, clears the held frame and sets max length to 4096.
// cfg_we_i writes max_payload_len; write it only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module meter_frame_deframer #(
  parameter int unsigned RX_DEPTH      = mfd_pkg::RxDepthDef,
  parameter int unsigned PAYLOAD_DEPTH = mfd_pkg::PayloadDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [12:0] cfg_wdata_i,
  input  wire logic        push_i,
  output logic             full_o,
  input  wire logic        action_i,
  input  wire logic [7:0]  rx_byte_i,
  output logic             empty_o,
  input  wire logic        pop_i,
  output logic [1:0]       status_o,
  output logic [15:0]      rtua_o,
  output logic [15:0]      terminal_id_o,
  output logic [5:0]       master_station_o,
  output logic [6:0]       frame_seq_o,
  output logic [2:0]       intra_seq_o,
  output logic [5:0]       func_code_o,
  output logic             abnormal_o,
  output logic             direction_o,
  output logic [12:0]      payload_len_o,
  output logic [7:0]       payload_byte_o,
  output logic             last_o
);

  mfd_pkg::item_t in_item, q_item;
  mfd_pkg::res_t  eng_res, out_q;
  logic           q_valid, q_pop, eng_valid, out_valid_q, load;

  assign in_item.action  = action_i;
  assign in_item.rx_byte = rx_byte_i;

  mfd_in_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .item_i  (in_item),
    .full_o  (full_o),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (q_pop)
  );

  mfd_engine #(
    .RX_DEPTH      (RX_DEPTH),
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .item_pop_o   (q_pop),
    .res_valid_o  (eng_valid),
    .res_o        (eng_res),
    .res_ready_i  (!out_valid_q)
  );

  // Load the result register when it is free; drop its valid on a transfer.
  assign load = eng_valid && !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= eng_res;
    end
  end

  assign empty_o          = !out_valid_q;
  assign status_o         = out_q.status;
  assign rtua_o           = out_q.rtua;
  assign terminal_id_o    = out_q.terminal_id;
  assign master_station_o = out_q.master_station;
  assign frame_seq_o      = out_q.frame_seq;
  assign intra_seq_o      = out_q.intra_seq;
  assign func_code_o      = out_q.func_code;
  assign abnormal_o       = out_q.abnormal;
  assign direction_o      = out_q.direction;
  assign payload_len_o    = out_q.payload_len;
  assign payload_byte_o   = out_q.payload_byte;
  assign last_o           = out_q.last;

endmodule
`default_nettype wire
